// ----- sv/dfp_pkg.sv -----
// Shared constants, the result type and a helper function of the decimal frame parser.
// Used by dfp_core and decimal_frame_parser; depends on nothing else.
package dfp_pkg;

    localparam int FRAC_DIGITS = 6;
    localparam int INT_WIDTH   = 32;

    localparam int FRAC_ACC_W  = $clog2(10 ** FRAC_DIGITS);
    localparam int FIDX_W      = $clog2(FRAC_DIGITS + 1);
    localparam int OUT_INT_W   = 32;
    localparam int OUT_FRAC_W  = 20;

    localparam logic [1:0] PH_IDLE = 2'd0;
    localparam logic [1:0] PH_INT  = 2'd1;
    localparam logic [1:0] PH_FRAC = 2'd2;

    localparam logic [7:0] RESYNC_BYTE = 8'hFF;
    localparam logic [7:0] ASCII_ZERO  = 8'd48;
    localparam logic [7:0] ASCII_NINE  = 8'd57;

    typedef struct packed {
        logic [OUT_INT_W-1:0]  int_part;
        logic [OUT_FRAC_W-1:0] frac_part;
        logic                  bad_digit;
        logic                  int_overflow;
    } t_result;

    // Weight of the fraction digit at position k, scaled to the full fraction width.
    // Positions at or beyond FRAC_DIGITS weigh nothing, so extra digits are dropped.
    function automatic logic [FRAC_ACC_W-1:0] frac_weight(input int k);
        logic [FRAC_ACC_W-1:0] w;
        w = FRAC_ACC_W'(1);
        for (int i = 0; i < FRAC_DIGITS; i++) begin
            if (i > k) begin
                w = FRAC_ACC_W'(w * FRAC_ACC_W'(10));
            end
        end
        if (k >= FRAC_DIGITS) begin
            w = '0;
        end
        return w;
    endfunction

endpackage

// ----- sv/dfp_core.sv -----
// Parser state and combinational next-state update for one received word.
// Depends on dfp_pkg for widths, phase codes and the fraction weights.
module dfp_core
    import dfp_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_fire,
    input  logic [7:0] i_byte,
    output logic       o_emit,
    output t_result    o_result
);

    logic [1:0]            r_phase,       n_phase;
    logic [6:0]            r_digits_left, n_digits_left;
    logic [INT_WIDTH-1:0]  r_frame_value, n_frame_value;
    logic [INT_WIDTH-1:0]  r_int_total,   n_int_total;
    logic [FRAC_ACC_W-1:0] r_frac_total,  n_frac_total;
    logic [FIDX_W-1:0]     r_frac_index,  n_frac_index;
    logic                  r_bad,         n_bad;
    logic                  r_ovf,         n_ovf;

    logic [FRAC_ACC_W-1:0] w_weight [FRAC_DIGITS+1];

    logic                   is_digit;
    logic [3:0]             digit;
    logic [INT_WIDTH+3:0]   frame_ext;
    logic [INT_WIDTH+3:0]   mac;
    logic                   mac_ovf;
    logic [INT_WIDTH-1:0]   mac_val;
    logic [INT_WIDTH:0]     total_sum;
    logic                   add_ovf;
    logic [FRAC_ACC_W-1:0]  frac_add;
    logic                   last_digit;
    logic [63:0]            int_ext;
    logic [63:0]            frac_ext;

    for (genvar k = 0; k <= FRAC_DIGITS; k++) begin : g_weight
        assign w_weight[k] = frac_weight(k);
    end

    always_comb begin
        is_digit   = (i_byte >= ASCII_ZERO) && (i_byte <= ASCII_NINE);
        digit      = is_digit ? 4'(i_byte - ASCII_ZERO) : 4'd0;
        frame_ext  = (INT_WIDTH+4)'(r_frame_value);
        mac        = (frame_ext << 3) + (frame_ext << 1) + (INT_WIDTH+4)'(digit);
        mac_ovf    = (mac[INT_WIDTH+3:INT_WIDTH] != 4'd0);
        mac_val    = mac_ovf ? {INT_WIDTH{1'b1}} : mac[INT_WIDTH-1:0];
        total_sum  = {1'b0, r_int_total} + {1'b0, mac_val};
        add_ovf    = total_sum[INT_WIDTH];
        frac_add   = r_frac_total
                   + FRAC_ACC_W'(w_weight[r_frac_index] * FRAC_ACC_W'(digit));
        last_digit = (r_digits_left == 7'd1);

        n_phase       = r_phase;
        n_digits_left = r_digits_left;
        n_frame_value = r_frame_value;
        n_int_total   = r_int_total;
        n_frac_total  = r_frac_total;
        n_frac_index  = r_frac_index;
        n_bad         = r_bad;
        n_ovf         = r_ovf;
        o_emit        = 1'b0;

        unique case (r_phase)
            PH_INT: begin
                n_bad         = r_bad | ~is_digit;
                n_ovf         = r_ovf | mac_ovf;
                n_frame_value = mac_val;
                n_digits_left = r_digits_left - 7'd1;
                if (last_digit) begin
                    n_int_total   = add_ovf ? {INT_WIDTH{1'b1}} : total_sum[INT_WIDTH-1:0];
                    n_ovf         = r_ovf | mac_ovf | add_ovf;
                    n_frame_value = '0;
                    n_phase       = PH_IDLE;
                end
            end
            PH_FRAC: begin
                n_bad         = r_bad | ~is_digit;
                n_frac_total  = frac_add;
                if (r_frac_index < FIDX_W'(FRAC_DIGITS)) begin
                    n_frac_index = r_frac_index + FIDX_W'(1);
                end
                n_digits_left = r_digits_left - 7'd1;
                if (last_digit) begin
                    o_emit = 1'b1;
                end
            end
            default: begin
                n_phase = PH_IDLE;
                if (i_byte != RESYNC_BYTE) begin
                    if (i_byte[7]) begin
                        if (i_byte[6:0] != 7'd0) begin
                            n_phase       = PH_INT;
                            n_digits_left = i_byte[6:0];
                            n_frame_value = '0;
                        end
                    end else begin
                        n_frac_total = '0;
                        n_frac_index = '0;
                        if (i_byte[6:0] == 7'd0) begin
                            o_emit = 1'b1;
                        end else begin
                            n_phase       = PH_FRAC;
                            n_digits_left = i_byte[6:0];
                        end
                    end
                end
            end
        endcase

        int_ext  = 64'(n_int_total);
        frac_ext = 64'(n_frac_total);
        o_result.int_part     = int_ext[OUT_INT_W-1:0];
        o_result.frac_part    = frac_ext[OUT_FRAC_W-1:0];
        o_result.bad_digit    = n_bad;
        o_result.int_overflow = n_ovf;

        if (o_emit) begin
            n_int_total   = '0;
            n_frac_total  = '0;
            n_frac_index  = '0;
            n_bad         = 1'b0;
            n_ovf         = 1'b0;
            n_phase       = PH_IDLE;
            n_digits_left = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase       <= PH_IDLE;
            r_digits_left <= '0;
            r_frame_value <= '0;
            r_int_total   <= '0;
            r_frac_total  <= '0;
            r_frac_index  <= '0;
            r_bad         <= 1'b0;
            r_ovf         <= 1'b0;
        end else if (i_fire) begin
            r_phase       <= n_phase;
            r_digits_left <= n_digits_left;
            r_frame_value <= n_frame_value;
            r_int_total   <= n_int_total;
            r_frac_total  <= n_frac_total;
            r_frac_index  <= n_frac_index;
            r_bad         <= n_bad;
            r_ovf         <= n_ovf;
        end
    end

endmodule

// ----- sv/decimal_frame_parser.sv -----
// Decimal frame parser: input word register, parser core, result register.
// A result is registered when the core takes the frame's last word.
// Throughput: one word per cycle; a word that ends a frame waits only while the
// result register is still held by a stalled consumer.
// Reset: synchronous, active low; the parser returns to idle with all totals cleared.
// Depends on dfp_pkg and dfp_core.
module decimal_frame_parser
    import dfp_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    output logic                  o_stall,
    input  logic [7:0]            i_rx_byte,
    output logic                  o_valid,
    input  logic                  i_stall,
    output logic [OUT_INT_W-1:0]  o_int_part,
    output logic [OUT_FRAC_W-1:0] o_frac_part,
    output logic                  o_bad_digit,
    output logic                  o_int_overflow
);

    logic       r_in_valid;
    logic [7:0] r_in_byte;
    logic       r_out_valid;
    t_result    r_out;

    logic       core_emit;
    t_result    core_result;
    logic       out_free;
    logic       fire;
    logic       in_accept;

    dfp_core u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_fire   (fire),
        .i_byte   (r_in_byte),
        .o_emit   (core_emit),
        .o_result (core_result)
    );

    assign out_free  = !r_out_valid || !i_stall;
    assign fire      = r_in_valid && (!core_emit || out_free);
    assign o_stall   = r_in_valid && !fire;
    assign in_accept = i_valid && !o_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_accept) begin
            r_in_valid <= 1'b1;
        end else if (fire) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_in_byte <= i_rx_byte;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (fire && core_emit) begin
            r_out_valid <= 1'b1;
        end else if (!i_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (fire && core_emit) begin
            r_out <= core_result;
        end
    end

    assign o_valid        = r_out_valid;
    assign o_int_part     = r_out.int_part;
    assign o_frac_part    = r_out.frac_part;
    assign o_bad_digit    = r_out.bad_digit;
    assign o_int_overflow = r_out.int_overflow;

endmodule
